// ===== src/landing_queue_with_urgent_promotion_top_assert.svh =====
// Assertion macros shared by the landing queue RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LANDING_QUEUE_WITH_URGENT_PROMOTION_TOP_ASSERT_SVH
`define LANDING_QUEUE_WITH_URGENT_PROMOTION_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define LQUP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LQUP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lqup_pkg.sv =====
// Shared types, constants and helpers for the landing queue.
// No dependencies.
package lqup_pkg;

  localparam int DEPTH    = 32;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int FLIGHT_W = 14;
  localparam int ORIGIN_W = 64;
  localparam int KIND_W   = 3;

  localparam logic [KIND_W-1:0] KIND_LANDED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LIST      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LIST_EMPTY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd5;

  localparam logic [1:0] FUNC_REQUEST = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_URGENT  = 2'd2;
  localparam logic [1:0] FUNC_END     = 2'd3;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_REL,
    OP_URG,
    OP_END
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [FLIGHT_W-1:0] flight;
    logic [ORIGIN_W-1:0] origin;
  } cmd_t;

  typedef struct packed {
    logic [FLIGHT_W-1:0] flight;
    logic [ORIGIN_W-1:0] origin;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RELW,
    ST_SRD,
    ST_SCMP,
    ST_MRD,
    ST_MWR,
    ST_LRD,
    ST_LOUT,
    ST_EMIT
  } state_t;

  // logical queue position to storage slot, circular from head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W + 1)'(DEPTH)) sum = sum - (IDX_W + 1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== src/lqup_front.sv =====
// Front end: takes requests, decodes the function code, and queues commands.
// Depends on lqup_pkg.
module lqup_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [lqup_pkg::FLIGHT_W-1:0] in_flight_number,
  input  logic [lqup_pkg::ORIGIN_W-1:0] in_origin_tag,
  output logic                          q_valid,
  output lqup_pkg::cmd_t                q_cmd,
  input  logic                          q_pop
);

  lqup_pkg::cmd_t slot_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  lqup_pkg::op_t  op_dec;
  logic           push;

  always_comb begin
    unique case (in_func)
      lqup_pkg::FUNC_REQUEST: op_dec = lqup_pkg::OP_REQ;
      lqup_pkg::FUNC_RELEASE: op_dec = lqup_pkg::OP_REL;
      lqup_pkg::FUNC_URGENT:  op_dec = lqup_pkg::OP_URG;
      default:                op_dec = lqup_pkg::OP_END;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= '{op: op_dec, flight: in_flight_number, origin: in_origin_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== src/lqup_back.sv =====
// Back end: queue storage, search and promotion sequencer, result register.
// Depends on lqup_pkg and the assertion macro header.
`include "landing_queue_with_urgent_promotion_top_assert.svh"
module lqup_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  lqup_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lqup_pkg::KIND_W-1:0]   out_kind,
  output logic [lqup_pkg::FLIGHT_W-1:0] out_flight,
  output logic [lqup_pkg::ORIGIN_W-1:0] out_origin,
  output logic                          out_last
);

  localparam int IW = lqup_pkg::IDX_W;
  localparam int CW = lqup_pkg::CNT_W;

  lqup_pkg::state_t state_r, state_nxt;
  lqup_pkg::cmd_t   cmd_r;
  lqup_pkg::entry_t mem [lqup_pkg::DEPTH];
  lqup_pkg::entry_t rd_data_r, save_r, wr_data;
  logic [IW-1:0]    head_r, idx_r, j_r, rd_addr, wr_addr;
  logic [CW-1:0]    count_r, urg_r;
  logic [lqup_pkg::KIND_W-1:0] emit_kind_r;
  logic             rd_en, wr_en, slot_free, out_load;
  logic             out_valid_r, out_last_r;
  logic [lqup_pkg::KIND_W-1:0]   out_kind_r;
  logic [lqup_pkg::FLIGHT_W-1:0] out_flight_r;
  logic [lqup_pkg::ORIGIN_W-1:0] out_origin_r;
  logic             is_tail, hit, empty, full;

  assign slot_free = !out_valid_r || !out_stall;
  assign is_tail   = (CW'(idx_r) == count_r - CW'(1));
  assign hit       = (rd_data_r.flight == cmd_r.flight);
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(lqup_pkg::DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lqup_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            lqup_pkg::OP_REQ: state_nxt = full ? lqup_pkg::ST_EMIT : lqup_pkg::ST_IDLE;
            lqup_pkg::OP_REL: state_nxt = empty ? lqup_pkg::ST_EMIT : lqup_pkg::ST_RELW;
            lqup_pkg::OP_URG: state_nxt = empty ? lqup_pkg::ST_EMIT : lqup_pkg::ST_SRD;
            default:          state_nxt = empty ? lqup_pkg::ST_EMIT : lqup_pkg::ST_LRD;
          endcase
        end
      end
      lqup_pkg::ST_RELW: state_nxt = lqup_pkg::ST_EMIT;
      lqup_pkg::ST_SRD:  state_nxt = lqup_pkg::ST_SCMP;
      lqup_pkg::ST_SCMP: begin
        if (hit) begin
          state_nxt = (CW'(idx_r) < urg_r) ? lqup_pkg::ST_IDLE : lqup_pkg::ST_MRD;
        end else begin
          state_nxt = is_tail ? lqup_pkg::ST_EMIT : lqup_pkg::ST_SRD;
        end
      end
      lqup_pkg::ST_MRD:
        state_nxt = (CW'(j_r) == urg_r) ? lqup_pkg::ST_IDLE : lqup_pkg::ST_MWR;
      lqup_pkg::ST_MWR:  state_nxt = lqup_pkg::ST_MRD;
      lqup_pkg::ST_LRD:  state_nxt = lqup_pkg::ST_LOUT;
      lqup_pkg::ST_LOUT: begin
        if (slot_free) state_nxt = is_tail ? lqup_pkg::ST_IDLE : lqup_pkg::ST_LRD;
      end
      lqup_pkg::ST_EMIT: begin
        if (slot_free) state_nxt = lqup_pkg::ST_IDLE;
      end
      default: state_nxt = lqup_pkg::ST_IDLE;
    endcase
  end

  // outputs: storage port controls and result load
  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = save_r;
    out_load = 1'b0;
    unique case (state_r)
      lqup_pkg::ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_cmd.op == lqup_pkg::OP_REQ && !full) begin
          wr_en   = 1'b1;
          wr_addr = lqup_pkg::phys(head_r, count_r[IW-1:0]);
          wr_data = '{flight: q_cmd.flight, origin: q_cmd.origin};
        end
        if (q_valid && q_cmd.op == lqup_pkg::OP_REL) begin
          rd_en   = 1'b1;
          rd_addr = head_r;
        end
      end
      lqup_pkg::ST_SRD, lqup_pkg::ST_LRD: begin
        rd_en   = 1'b1;
        rd_addr = lqup_pkg::phys(head_r, idx_r);
      end
      lqup_pkg::ST_MRD: begin
        if (CW'(j_r) == urg_r) begin
          // hole has reached the back of the urgent group
          wr_en   = 1'b1;
          wr_addr = lqup_pkg::phys(head_r, j_r);
        end else begin
          rd_en   = 1'b1;
          rd_addr = lqup_pkg::phys(head_r, j_r - IW'(1));
        end
      end
      lqup_pkg::ST_MWR: begin
        wr_en   = 1'b1;
        wr_addr = lqup_pkg::phys(head_r, j_r);
        wr_data = rd_data_r;
      end
      lqup_pkg::ST_LOUT, lqup_pkg::ST_EMIT: out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    if (state_r == lqup_pkg::ST_SCMP) save_r <= rd_data_r;
    if (out_load) begin
      out_last_r <= (state_r == lqup_pkg::ST_EMIT) || is_tail;
      if (state_r == lqup_pkg::ST_LOUT) begin
        out_kind_r   <= lqup_pkg::KIND_LIST;
        out_flight_r <= rd_data_r.flight;
        out_origin_r <= rd_data_r.origin;
      end else begin
        out_kind_r   <= emit_kind_r;
        out_flight_r <= (emit_kind_r == lqup_pkg::KIND_LANDED) ? rd_data_r.flight : '0;
        out_origin_r <= (emit_kind_r == lqup_pkg::KIND_LANDED) ? rd_data_r.origin : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lqup_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      urg_r       <= '0;
      idx_r       <= '0;
      j_r         <= '0;
      emit_kind_r <= lqup_pkg::KIND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        lqup_pkg::ST_IDLE: begin
          idx_r <= '0;
          if (q_valid) begin
            case (q_cmd.op)
              lqup_pkg::OP_REQ: begin
                if (full) emit_kind_r <= lqup_pkg::KIND_FULL;
                else count_r <= count_r + CW'(1);
              end
              lqup_pkg::OP_REL: emit_kind_r <= lqup_pkg::KIND_NONE;
              lqup_pkg::OP_URG: emit_kind_r <= lqup_pkg::KIND_NOT_FOUND;
              default:          emit_kind_r <= lqup_pkg::KIND_LIST_EMPTY;
            endcase
          end
        end
        lqup_pkg::ST_RELW: begin
          emit_kind_r <= lqup_pkg::KIND_LANDED;
          head_r      <= lqup_pkg::phys(head_r, IW'(1));
          count_r     <= count_r - CW'(1);
          if (urg_r != '0) urg_r <= urg_r - CW'(1);
        end
        lqup_pkg::ST_SCMP: begin
          j_r <= idx_r;
          if (!hit) idx_r <= idx_r + IW'(1);
        end
        lqup_pkg::ST_MRD: begin
          if (CW'(j_r) == urg_r) urg_r <= urg_r + CW'(1);
        end
        lqup_pkg::ST_MWR: j_r <= j_r - IW'(1);
        lqup_pkg::ST_LOUT: begin
          if (slot_free) begin
            idx_r <= idx_r + IW'(1);
            if (is_tail) begin
              count_r <= '0;
              urg_r   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_flight = out_flight_r;
  assign out_origin = out_origin_r;
  assign out_last   = out_last_r;

  `LQUP_ASSERT_ALWAYS(a_urg_le_count, urg_r <= count_r, "urgent group larger than queue")
  `LQUP_ASSERT_ALWAYS(a_count_le_depth, count_r <= CW'(lqup_pkg::DEPTH), "queue over depth")
  `LQUP_ASSERT_NEXT(a_drain_clears, state_r == lqup_pkg::ST_LOUT && out_load && is_tail, count_r == '0 && urg_r == '0, "drain left entries")
  `LQUP_ASSERT_NEXT(a_load_valid, out_load, out_valid_r, "loaded result not presented")

endmodule

// ===== src/landing_queue_with_urgent_promotion_top.sv =====
// Landing queue with urgent promotion. A request appends a flight at the tail
// (or reports full), a release lands the head, an urgent command moves the first
// matching flight to the back of the urgent group unless it is already in that
// group, and end drains the queue as a listing. Commands are taken into a
// two-deep queue and executed one at a time against a single-port store with
// registered reads. The store port does one read or one write a cycle, and an
// output stall holds the command in progress.
// Depends on lqup_pkg, lqup_front and lqup_back.
module landing_queue_with_urgent_promotion_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [lqup_pkg::FLIGHT_W-1:0] in_flight_number,
  input  logic [lqup_pkg::ORIGIN_W-1:0] in_origin_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lqup_pkg::KIND_W-1:0]   out_kind,
  output logic [lqup_pkg::FLIGHT_W-1:0] out_flight,
  output logic [lqup_pkg::ORIGIN_W-1:0] out_origin,
  output logic                          out_last
);

  logic           q_valid, q_pop;
  lqup_pkg::cmd_t q_cmd;

  lqup_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_flight_number (in_flight_number),
    .in_origin_tag    (in_origin_tag),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop)
  );

  lqup_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_flight (out_flight),
    .out_origin (out_origin),
    .out_last   (out_last)
  );

endmodule
